// ===== rtl/mau_pkg.sv =====
// mau_pkg: operation codes and sequencer states of the modular arithmetic unit.
// No dependencies; used by modular_arithmetic_unit.
`default_nettype none

package mau_pkg;

	localparam int unsigned KIND_W = 3;

	localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POW = 3'd4;
	localparam logic [KIND_W-1:0] KIND_INV = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_A,
		ST_RED_B,
		ST_EXEC,
		ST_POW_CHK,
		ST_POW_MUL,
		ST_POW_SQR,
		ST_FIN_MUL,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/mau_mulmod.sv =====
// mau_mulmod: shared bit-serial modular multiplier, one multiplier bit per cycle.
// Stand-alone; instantiated by modular_arithmetic_unit.
`default_nettype none

module mau_mulmod #(
	parameter int unsigned MOD_WIDTH = 31
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [MOD_WIDTH-1:0] x,
	input  wire logic [MOD_WIDTH-1:0] y,
	input  wire logic [MOD_WIDTH-1:0] m,
	output logic                      busy,
	output logic                      done,
	output logic [MOD_WIDTH-1:0]      prod
);

	localparam int unsigned CW = $clog2(MOD_WIDTH);

	logic [MOD_WIDTH-1:0] x_q, y_q, acc_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q;

	logic [MOD_WIDTH:0]   m_x, dbl, red1, sum, red2;

	// acc = 2*acc + bit*y, kept below m with two conditional subtracts (y < m)
	always_comb begin
		m_x  = {1'b0, m};
		dbl  = {acc_q, 1'b0};
		red1 = (dbl >= m_x) ? dbl - m_x : dbl;
		sum  = {1'b0, red1[MOD_WIDTH-1:0]} + (x_q[MOD_WIDTH-1] ? {1'b0, y_q} : '0);
		red2 = (sum >= m_x) ? sum - m_x : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(MOD_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			acc_q <= red2[MOD_WIDTH-1:0];
			x_q   <= {x_q[MOD_WIDTH-2:0], 1'b0};
		end else if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

// ===== rtl/modular_arithmetic_unit.sv =====
// modular_arithmetic_unit: add/sub/mul/div/pow/inverse modulo a programmable modulus.
// Each request first reduces both operands on the shared multiplier (x*1); add/sub then finish
// directly, mul runs one final multiply, power runs square-and-multiply over the exponent bits,
// inverse is power with e = modulus-2 and divide adds a final multiply; modulus < 2 gives 0.
// One request at a time: in_ready only while idle; a result register lets the next request
// start while a result waits. Async reset: idle, modulus 1000000007.
`default_nettype none

module modular_arithmetic_unit #(
	parameter int unsigned MOD_WIDTH = 31
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration write channel (modulus)
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [MOD_WIDTH-1:0]         modulus,
	// request channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [mau_pkg::KIND_W-1:0]   kind,
	input  wire logic [MOD_WIDTH-1:0]         operand_a,
	input  wire logic [MOD_WIDTH-1:0]         operand_b,
	input  wire logic [MOD_WIDTH-1:0]         exponent,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [MOD_WIDTH-1:0]              result
);

	localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(32'd1000000007);

	mau_pkg::state_t state_q, state_d;

	logic [MOD_WIDTH-1:0]        modulus_q;
	logic [MOD_WIDTH-1:0]        a_q, b_q, e_q, acc_q, base_q, out_q;
	logic [mau_pkg::KIND_W-1:0]  kind_q;
	logic                        out_valid_q, mm_pend_q;

	logic                        accept, small_mod, out_free;
	logic                        mm_start, mm_busy, mm_done;
	logic [MOD_WIDTH-1:0]        mm_x, mm_y, mm_prod;
	logic [MOD_WIDTH:0]          add_s, sub_d;
	logic [MOD_WIDTH-1:0]        add_r, sub_r;

	assign accept    = in_valid && in_ready;
	assign small_mod = modulus_q < MOD_WIDTH'(2);   // modulus 0 or 1: result is always 0
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// Modulus register; the host must write it only while no request is in flight; this block leaves that to the host.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET;
		end else if (cfg_valid) begin
			modulus_q <= modulus;
		end
	end

	// Single-step add and subtract on reduced operands.
	always_comb begin
		add_s = {1'b0, a_q} + {1'b0, b_q};
		add_r = (add_s >= {1'b0, modulus_q}) ? MOD_WIDTH'(add_s - {1'b0, modulus_q})
		                                     : add_s[MOD_WIDTH-1:0];
		sub_d = {1'b0, a_q} - {1'b0, b_q};
		sub_r = sub_d[MOD_WIDTH] ? MOD_WIDTH'(sub_d + {1'b0, modulus_q})
		                         : sub_d[MOD_WIDTH-1:0];
	end

	// Shared multiplier: operand reduction (x*1), power steps and final multiply.
	mau_mulmod #(
		.MOD_WIDTH(MOD_WIDTH)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.x     (mm_x),
		.y     (mm_y),
		.m     (modulus_q),
		.busy  (mm_busy),
		.done  (mm_done),
		.prod  (mm_prod)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mau_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = small_mod ? mau_pkg::ST_OUT : mau_pkg::ST_RED_A;
				end
			end
			mau_pkg::ST_RED_A: begin
				if (mm_done) begin
					state_d = mau_pkg::ST_RED_B;
				end
			end
			mau_pkg::ST_RED_B: begin
				if (mm_done) begin
					state_d = mau_pkg::ST_EXEC;
				end
			end
			mau_pkg::ST_EXEC: begin
				priority if (kind_q == mau_pkg::KIND_MUL) begin
					state_d = mau_pkg::ST_FIN_MUL;
				end else if (kind_q == mau_pkg::KIND_DIV || kind_q == mau_pkg::KIND_POW ||
				             kind_q == mau_pkg::KIND_INV) begin
					state_d = mau_pkg::ST_POW_CHK;
				end else begin
					state_d = mau_pkg::ST_OUT;
				end
			end
			mau_pkg::ST_POW_CHK: begin
				priority if (e_q == '0) begin
					state_d = (kind_q == mau_pkg::KIND_DIV) ? mau_pkg::ST_FIN_MUL
					                                        : mau_pkg::ST_OUT;
				end else if (e_q[0]) begin
					state_d = mau_pkg::ST_POW_MUL;
				end else begin
					state_d = mau_pkg::ST_POW_SQR;
				end
			end
			mau_pkg::ST_POW_MUL: begin
				if (mm_done) begin
					state_d = mau_pkg::ST_POW_SQR;
				end
			end
			mau_pkg::ST_POW_SQR: begin
				if (mm_done) begin
					state_d = mau_pkg::ST_POW_CHK;
				end
			end
			mau_pkg::ST_FIN_MUL: begin
				if (mm_done) begin
					state_d = mau_pkg::ST_OUT;
				end
			end
			mau_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = mau_pkg::ST_IDLE;
				end
			end
			default: state_d = mau_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and multiplier operand select
	always_comb begin
		in_ready = 1'b0;
		mm_x     = a_q;
		mm_y     = MOD_WIDTH'(1);
		mm_start = 1'b0;
		unique case (state_q)
			mau_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			mau_pkg::ST_RED_A: begin
				mm_x     = a_q;
				mm_y     = MOD_WIDTH'(1);
				mm_start = !mm_pend_q && !mm_busy;
			end
			mau_pkg::ST_RED_B: begin
				mm_x     = b_q;
				mm_y     = MOD_WIDTH'(1);
				mm_start = !mm_pend_q && !mm_busy;
			end
			mau_pkg::ST_POW_MUL: begin
				mm_x     = acc_q;
				mm_y     = base_q;
				mm_start = !mm_pend_q && !mm_busy;
			end
			mau_pkg::ST_POW_SQR: begin
				mm_x     = base_q;
				mm_y     = base_q;
				mm_start = !mm_pend_q && !mm_busy;
			end
			mau_pkg::ST_FIN_MUL: begin
				mm_x     = a_q;
				mm_y     = (kind_q == mau_pkg::KIND_DIV) ? acc_q : b_q;
				mm_start = !mm_pend_q && !mm_busy;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mau_pkg::ST_IDLE;
			mm_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mm_start) begin
				mm_pend_q <= 1'b1;
			end else if (mm_done) begin
				mm_pend_q <= 1'b0;
			end
			if (state_q == mau_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operand and working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			mau_pkg::ST_IDLE: begin
				if (accept) begin
					a_q    <= operand_a;
					b_q    <= operand_b;
					e_q    <= exponent;
					kind_q <= kind;
					acc_q  <= '0;
				end
			end
			mau_pkg::ST_RED_A: begin
				if (mm_done) begin
					a_q <= mm_prod;
				end
			end
			mau_pkg::ST_RED_B: begin
				if (mm_done) begin
					b_q <= mm_prod;
				end
			end
			mau_pkg::ST_EXEC: begin
				// power runs right to left over e; inverse/divide use e = modulus-2
				unique case (kind_q)
					mau_pkg::KIND_ADD: acc_q <= add_r;
					mau_pkg::KIND_SUB: acc_q <= sub_r;
					mau_pkg::KIND_DIV: begin
						base_q <= b_q;
						e_q    <= modulus_q - MOD_WIDTH'(2);
						acc_q  <= MOD_WIDTH'(1);
					end
					mau_pkg::KIND_POW: begin
						base_q <= a_q;
						acc_q  <= MOD_WIDTH'(1);
					end
					mau_pkg::KIND_INV: begin
						base_q <= a_q;
						e_q    <= modulus_q - MOD_WIDTH'(2);
						acc_q  <= MOD_WIDTH'(1);
					end
					default: acc_q <= '0;   // multiply overwrites; unused kinds give 0
				endcase
			end
			mau_pkg::ST_POW_MUL: begin
				if (mm_done) begin
					acc_q <= mm_prod;
				end
			end
			mau_pkg::ST_POW_SQR: begin
				if (mm_done) begin
					base_q <= mm_prod;
					e_q    <= e_q >> 1;
				end
			end
			mau_pkg::ST_FIN_MUL: begin
				if (mm_done) begin
					acc_q <= mm_prod;
				end
			end
			mau_pkg::ST_OUT: begin
				if (out_free) begin
					out_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

	// An accepted request always leaves idle.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != mau_pkg::ST_IDLE)
		else $error("request accepted but sequencer stayed idle");

	// Multiplier completions only answer an outstanding start.
	a_done_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> mm_pend_q)
		else $error("multiplier done without pending start");

	// A multiplier start is always taken: afterwards the unit is busy and the start is pending.
	a_start_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |=> mm_busy && mm_pend_q)
		else $error("multiplier start not taken");

	// Power loop only runs for the exponentiating kinds.
	a_pow_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mau_pkg::ST_POW_MUL || state_q == mau_pkg::ST_POW_SQR) |->
		(kind_q == mau_pkg::KIND_DIV || kind_q == mau_pkg::KIND_POW ||
		 kind_q == mau_pkg::KIND_INV))
		else $error("power loop entered for wrong kind");

	// Finishing an item posts a result and frees the input side.
	a_out_posts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mau_pkg::ST_OUT && out_free) |=> out_valid_q && in_ready)
		else $error("finished item did not post a result");

endmodule

`default_nettype wire
